@@ rtl/smeu_pkg.sv @@
// Shared types, opcode and status codes for the stack machine execute unit.
// No dependencies; smeu_dp, smeu_ctrl and the core refer to it by scoped names.
package smeu_pkg;

	localparam int STACK_WORDS_DEF  = 256;
	localparam int MEMORY_BYTES_DEF = 65536;

	// Operation codes
	localparam logic [5:0] K_NOP  = 6'd0;
	localparam logic [5:0] K_HALT = 6'd1;
	localparam logic [5:0] K_PUSH = 6'd2;
	localparam logic [5:0] K_POP  = 6'd3;
	localparam logic [5:0] K_UADD = 6'd4;
	localparam logic [5:0] K_USUB = 6'd5;
	localparam logic [5:0] K_UMUL = 6'd6;
	localparam logic [5:0] K_UDIV = 6'd7;
	localparam logic [5:0] K_UREM = 6'd8;
	localparam logic [5:0] K_SADD = 6'd9;
	localparam logic [5:0] K_SSUB = 6'd10;
	localparam logic [5:0] K_SMUL = 6'd11;
	localparam logic [5:0] K_SDIV = 6'd12;
	localparam logic [5:0] K_SREM = 6'd13;
	localparam logic [5:0] K_SHL  = 6'd14;
	localparam logic [5:0] K_SHR  = 6'd15;
	localparam logic [5:0] K_AND  = 6'd16;
	localparam logic [5:0] K_OR   = 6'd17;
	localparam logic [5:0] K_XOR  = 6'd18;
	localparam logic [5:0] K_NOR  = 6'd19;
	localparam logic [5:0] K_BEQ  = 6'd20;
	localparam logic [5:0] K_BNE  = 6'd21;
	localparam logic [5:0] K_BLTZ = 6'd22;
	localparam logic [5:0] K_BLEZ = 6'd23;
	localparam logic [5:0] K_BGTZ = 6'd24;
	localparam logic [5:0] K_BGEZ = 6'd25;
	localparam logic [5:0] K_CALL = 6'd26;
	localparam logic [5:0] K_JUMP = 6'd27;
	localparam logic [5:0] K_ST8  = 6'd28;
	localparam logic [5:0] K_ST1  = 6'd31;
	localparam logic [5:0] K_LD8  = 6'd32;
	localparam logic [5:0] K_LD1  = 6'd35;

	// Status codes
	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_UNDER = 3'd1;
	localparam logic [2:0] ST_OVER  = 3'd2;
	localparam logic [2:0] ST_DIV0  = 3'd3;
	localparam logic [2:0] ST_ADDR  = 3'd4;
	localparam logic [2:0] ST_INV   = 3'd5;

	// PC step selects
	localparam logic [1:0] PC_HOLD = 2'd0;
	localparam logic [1:0] PC_ONE  = 2'd1;
	localparam logic [1:0] PC_NINE = 2'd2;

	typedef struct packed {
		logic [5:0]  kind;
		logic [63:0] immediate;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] next_pc;
		logic        halted;
		logic [63:0] stack_top;
		logic [8:0]  stack_count;
	} result_t;

	typedef struct packed {
		logic       cap_in;
		logic [1:0] pc_step;
		logic       pc_ld_tos;
		logic       halt_set;
		logic       rd_req;
		logic       rd_second;
		logic       opa_cap;
		logic       pop1;
		logic       pop2;
		logic       push;
		logic       call_wr;
		logic       tos_zero;
		logic       tos_cap;
		logic       mul_start;
		logic       div_start;
		logic       clr_wr;
		logic       st_wr;
		logic       ld_rd;
		logic       ld_cap;
		logic       bcnt_clr;
		logic       bcnt_inc;
		logic       out_ld;
		logic [2:0] status;
		logic [5:0] op;
	} cmd_t;

	typedef struct packed {
		logic halted;
		logic empty;
		logic lt2;
		logic full;
		logic addr_ok;
		logic b_zero;
		logic br_taken;
		logic mul_done;
		logic div_done;
		logic bcnt_last;
		logic clr_done;
	} sts_t;

	// index of the last byte of an access, from the low opcode bits
	function automatic logic [2:0] size_last(input logic [1:0] code);
		logic [2:0] r;
		case (code)
			2'd0: r = 3'd7;
			2'd1: r = 3'd3;
			2'd2: r = 3'd1;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/smeu_mul.sv @@
// 64x64 low-half multiplier, one shared 32x32 product per cycle.
// Depends on nothing but the clock and reset.
module smeu_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] prod
);
	logic        busy_q;
	logic        done_q;
	logic [1:0]  step_q;
	logic [63:0] pp_q;
	logic [63:0] acc_q;
	logic [31:0] mx;
	logic [31:0] my;

	// lo*lo, lo*hi, hi*lo; hi*hi does not reach the low word
	assign mx = (step_q == 2'd2) ? a[63:32] : a[31:0];
	assign my = (step_q == 2'd1) ? b[63:32] : b[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			pp_q <= 64'(mx) * 64'(my);
			case (step_q)
				2'd0: acc_q <= acc_q;
				2'd1: acc_q <= pp_q;
				default: acc_q <= acc_q + {pp_q[31:0], 32'd0};
			endcase
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule

@@ rtl/smeu_div.sv @@
// Radix-2 restoring divider, 64 iterations plus a sign fix-up step.
// Signed mode works on magnitudes; remainder takes the dividend's sign.
module smeu_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        sgn,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] quo,
	output logic [63:0] rem
);
	logic        busy_q;
	logic        fix_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] quo_q;
	logic [63:0] rem_q;
	logic [63:0] d_q;
	logic        nq_q;
	logic        nr_q;
	logic        na;
	logic        nb;
	logic [63:0] ma;
	logic [63:0] mb;
	logic [64:0] r2;
	logic [65:0] diff;

	assign na   = sgn & a[63];
	assign nb   = sgn & b[63];
	assign ma   = na ? (64'd0 - a) : a;
	assign mb   = nb ? (64'd0 - b) : b;
	assign r2   = {rem_q, quo_q[63]};
	assign diff = {1'b0, r2} - {2'b00, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fix_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else begin
			done_q <= 1'b0;
			fix_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					fix_q  <= 1'b1;
				end
			end
			if (fix_q)
				done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= ma;
			rem_q <= 64'd0;
			d_q   <= mb;
			nq_q  <= na ^ nb;
			nr_q  <= na;
		end else if (busy_q) begin
			if (!diff[65]) begin
				rem_q <= diff[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= r2[63:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end else if (fix_q) begin
			if (nq_q)
				quo_q <= 64'd0 - quo_q;
			if (nr_q)
				rem_q <= 64'd0 - rem_q;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;
endmodule

@@ rtl/smeu_dp.sv @@
// Datapath: pc, halt flag, operand stack memory with cached top, byte data
// memory, ALU, multiplier, divider and result register. Uses smeu_pkg.
module smeu_dp #(
	parameter int STACK_WORDS  = smeu_pkg::STACK_WORDS_DEF,
	parameter int MEMORY_BYTES = smeu_pkg::MEMORY_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [63:0]      imm,
	input  smeu_pkg::cmd_t   cmd,
	output smeu_pkg::sts_t   sts,
	output smeu_pkg::result_t res
);
	localparam int SAW = $clog2(STACK_WORDS);
	localparam int DW  = $clog2(STACK_WORDS + 1);
	localparam int MAW = $clog2(MEMORY_BYTES);

	logic [63:0] stk [STACK_WORDS];
	logic [7:0]  dmem [MEMORY_BYTES];

	logic [31:0]  pc_q;
	logic         halt_q;
	logic [DW-1:0] depth_q;
	logic [63:0]  tos_q;
	logic [63:0]  imm_q;
	logic [63:0]  opa_q;
	logic [63:0]  stk_rd_q;
	logic [63:0]  ld_q;
	logic [7:0]   dm_rd_q;
	logic [2:0]   bcnt_q;
	logic [MAW-1:0] clr_q;
	smeu_pkg::result_t res_q;

	logic [DW-1:0]  depth_m1;
	logic [DW-1:0]  depth_m2;
	logic [SAW-1:0] stk_wa;
	logic [SAW-1:0] stk_ra;
	logic [63:0]    stk_wd;
	logic           stk_we;
	logic [MAW-1:0] m_idx;
	logic [2:0]     last;
	logic [63:0]    lim;
	logic [63:0]    alu;
	logic [63:0]    push_val;
	logic           br;
	logic           mul_done;
	logic [63:0]    mul_p;
	logic           div_done;
	logic [63:0]    quo;
	logic [63:0]    rem;

	assign depth_m1 = depth_q - DW'(1);
	assign depth_m2 = depth_q - DW'(2);
	assign stk_wa   = cmd.call_wr ? depth_m1[SAW-1:0] : depth_q[SAW-1:0];
	assign stk_ra   = cmd.rd_second ? depth_m2[SAW-1:0] : depth_m1[SAW-1:0];
	assign stk_wd   = cmd.call_wr ? {32'd0, pc_q} : push_val;
	assign stk_we   = cmd.push | cmd.call_wr;
	assign last     = smeu_pkg::size_last(cmd.op[1:0]);
	assign lim      = 64'(MEMORY_BYTES - 1) - 64'(last);
	assign m_idx    = tos_q[MAW-1:0] + MAW'(bcnt_q);

	smeu_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (opa_q),
		.b      (tos_q),
		.done   (mul_done),
		.prod   (mul_p)
	);

	smeu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.sgn    ((cmd.op == smeu_pkg::K_SDIV) || (cmd.op == smeu_pkg::K_SREM)),
		.a      (opa_q),
		.b      (tos_q),
		.done   (div_done),
		.quo    (quo),
		.rem    (rem)
	);

	// a = second word, b = top word
	always_comb begin
		case (cmd.op) inside
			smeu_pkg::K_UADD, smeu_pkg::K_SADD: alu = opa_q + tos_q;
			smeu_pkg::K_USUB, smeu_pkg::K_SSUB: alu = opa_q - tos_q;
			smeu_pkg::K_SHL: alu = (tos_q >= 64'd64) ? 64'd0 : (opa_q << tos_q[5:0]);
			smeu_pkg::K_SHR: alu = (tos_q >= 64'd64) ? 64'd0 : (opa_q >> tos_q[5:0]);
			smeu_pkg::K_AND: alu = opa_q & tos_q;
			smeu_pkg::K_OR:  alu = opa_q | tos_q;
			smeu_pkg::K_XOR: alu = opa_q ^ tos_q;
			smeu_pkg::K_NOR: alu = ~(opa_q | tos_q);
			default: alu = 64'd0;
		endcase
	end

	always_comb begin
		case (cmd.op) inside
			smeu_pkg::K_PUSH: push_val = imm_q;
			smeu_pkg::K_UMUL, smeu_pkg::K_SMUL: push_val = mul_p;
			smeu_pkg::K_UDIV, smeu_pkg::K_SDIV: push_val = quo;
			smeu_pkg::K_UREM, smeu_pkg::K_SREM: push_val = rem;
			[smeu_pkg::K_LD8:smeu_pkg::K_LD1]: push_val = ld_q;
			default: push_val = alu;
		endcase
	end

	// branch tests the signed second word
	always_comb begin
		case (cmd.op)
			smeu_pkg::K_BEQ:  br = (opa_q == 64'd0);
			smeu_pkg::K_BNE:  br = (opa_q != 64'd0);
			smeu_pkg::K_BLTZ: br = opa_q[63];
			smeu_pkg::K_BLEZ: br = opa_q[63] | (opa_q == 64'd0);
			smeu_pkg::K_BGTZ: br = !opa_q[63] & (opa_q != 64'd0);
			default: br = !opa_q[63];
		endcase
	end

	always_ff @(posedge clk) begin
		if (stk_we)
			stk[stk_wa] <= stk_wd;
		if (cmd.rd_req)
			stk_rd_q <= stk[stk_ra];
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_wr)
			dmem[clr_q] <= 8'd0;
		else if (cmd.st_wr)
			dmem[m_idx] <= opa_q[{bcnt_q, 3'b000} +: 8];
		if (cmd.ld_rd)
			dm_rd_q <= dmem[m_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= 32'd0;
			halt_q  <= 1'b0;
			depth_q <= '0;
			tos_q   <= 64'd0;
			bcnt_q  <= 3'd0;
			clr_q   <= '0;
		end else begin
			if (cmd.pc_step == smeu_pkg::PC_ONE)
				pc_q <= pc_q + 32'd1;
			else if (cmd.pc_step == smeu_pkg::PC_NINE)
				pc_q <= pc_q + 32'd9;
			else if (cmd.pc_ld_tos || cmd.call_wr)
				pc_q <= tos_q[31:0];
			if (cmd.halt_set)
				halt_q <= 1'b1;
			if (cmd.pop1)
				depth_q <= depth_m1;
			else if (cmd.pop2)
				depth_q <= depth_m2;
			else if (cmd.push)
				depth_q <= depth_q + DW'(1);
			if (cmd.push)
				tos_q <= push_val;
			else if (cmd.call_wr)
				tos_q <= {32'd0, pc_q};
			else if (cmd.tos_zero)
				tos_q <= 64'd0;
			else if (cmd.tos_cap)
				tos_q <= stk_rd_q;
			if (cmd.bcnt_clr)
				bcnt_q <= 3'd0;
			else if (cmd.bcnt_inc)
				bcnt_q <= bcnt_q + 3'd1;
			if (cmd.clr_wr)
				clr_q <= clr_q + MAW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_in)
			imm_q <= imm;
		if (cmd.opa_cap)
			opa_q <= stk_rd_q;
		if (cmd.bcnt_clr)
			ld_q <= 64'd0;
		else if (cmd.ld_cap)
			ld_q[{bcnt_q, 3'b000} +: 8] <= dm_rd_q;
		if (cmd.out_ld) begin
			res_q.status      <= cmd.status;
			res_q.next_pc     <= pc_q;
			res_q.halted      <= halt_q;
			res_q.stack_top   <= tos_q;
			res_q.stack_count <= 9'(depth_q);
		end
	end

	assign sts.halted    = halt_q;
	assign sts.empty     = (depth_q == '0);
	assign sts.lt2       = (depth_q < DW'(2));
	assign sts.full      = (depth_q == DW'(STACK_WORDS));
	assign sts.addr_ok   = (tos_q <= lim);
	assign sts.b_zero    = (tos_q == 64'd0);
	assign sts.br_taken  = br;
	assign sts.mul_done  = mul_done;
	assign sts.div_done  = div_done;
	assign sts.bcnt_last = (bcnt_q == last);
	assign sts.clr_done  = (clr_q == MAW'(MEMORY_BYTES - 1));
	assign res = res_q;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(STACK_WORDS))
		else $error("stack depth beyond capacity");
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q)
		else $error("halt flag cleared");
	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_ld && depth_q == '0) |-> (tos_q == 64'd0))
		else $error("empty stack reports nonzero top");
endmodule

@@ rtl/smeu_ctrl.sv @@
// Controller state machine: sequences each instruction through the datapath
// and owns both handshakes. Uses smeu_pkg command and status structs.
module smeu_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  logic [5:0]     kind,
	output logic           result_valid,
	input  logic           result_stall,
	input  smeu_pkg::sts_t sts,
	output smeu_pkg::cmd_t cmd
);
	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_DEC  = 4'd2;
	localparam logic [3:0] S_OPA  = 4'd3;
	localparam logic [3:0] S_EXEC = 4'd4;
	localparam logic [3:0] S_MUL  = 4'd5;
	localparam logic [3:0] S_DIV  = 4'd6;
	localparam logic [3:0] S_STW  = 4'd7;
	localparam logic [3:0] S_LDR  = 4'd8;
	localparam logic [3:0] S_LDC  = 4'd9;
	localparam logic [3:0] S_PUSH = 4'd10;
	localparam logic [3:0] S_RF1  = 4'd11;
	localparam logic [3:0] S_RF2  = 4'd12;
	localparam logic [3:0] S_OUT  = 4'd13;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic [5:0] kind_q;
	logic [2:0] st_q;
	logic [2:0] st_d;
	logic       res_v_q;

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = res_v_q;

	always_comb begin
		cmd        = '0;
		cmd.op     = kind_q;
		cmd.status = st_q;
		state_d    = state_q;
		st_d       = st_q;
		unique case (state_q)
			S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_done)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (item_valid) begin
					cmd.cap_in = 1'b1;
					st_d       = smeu_pkg::ST_OK;
					state_d    = S_DEC;
				end
			end
			S_DEC: begin
				state_d = S_OUT;
				if (!sts.halted) begin
					cmd.pc_step = smeu_pkg::PC_ONE;
					unique case (kind_q) inside
						smeu_pkg::K_NOP: state_d = S_OUT;
						smeu_pkg::K_HALT: cmd.halt_set = 1'b1;
						smeu_pkg::K_PUSH: begin
							if (sts.full)
								st_d = smeu_pkg::ST_OVER;
							else begin
								cmd.pc_step = smeu_pkg::PC_NINE;
								cmd.push    = 1'b1;
							end
						end
						smeu_pkg::K_POP: begin
							if (sts.empty)
								st_d = smeu_pkg::ST_UNDER;
							else begin
								cmd.pop1 = 1'b1;
								state_d  = S_RF1;
							end
						end
						smeu_pkg::K_CALL, smeu_pkg::K_JUMP,
						[smeu_pkg::K_LD8:smeu_pkg::K_LD1]: begin
							if (sts.empty)
								st_d = smeu_pkg::ST_UNDER;
							else
								state_d = S_EXEC;
						end
						[smeu_pkg::K_UADD:smeu_pkg::K_BGEZ],
						[smeu_pkg::K_ST8:smeu_pkg::K_ST1]: begin
							if (sts.lt2)
								st_d = smeu_pkg::ST_UNDER;
							else begin
								cmd.rd_req    = 1'b1;
								cmd.rd_second = 1'b1;
								state_d       = S_OPA;
							end
						end
						default: st_d = smeu_pkg::ST_INV;
					endcase
				end
			end
			S_OPA: begin
				cmd.opa_cap = 1'b1;
				state_d     = S_EXEC;
			end
			S_EXEC: begin
				unique case (kind_q) inside
					smeu_pkg::K_CALL: begin
						cmd.call_wr = 1'b1;
						state_d     = S_OUT;
					end
					smeu_pkg::K_JUMP: begin
						cmd.pc_ld_tos = 1'b1;
						cmd.pop1      = 1'b1;
						state_d       = S_RF1;
					end
					[smeu_pkg::K_LD8:smeu_pkg::K_LD1]: begin
						cmd.pop1 = 1'b1;
						if (!sts.addr_ok) begin
							st_d    = smeu_pkg::ST_ADDR;
							state_d = S_RF1;
						end else begin
							cmd.bcnt_clr = 1'b1;
							state_d      = S_LDR;
						end
					end
					smeu_pkg::K_UMUL, smeu_pkg::K_SMUL: begin
						cmd.pop2      = 1'b1;
						cmd.mul_start = 1'b1;
						state_d       = S_MUL;
					end
					smeu_pkg::K_UDIV, smeu_pkg::K_UREM,
					smeu_pkg::K_SDIV, smeu_pkg::K_SREM: begin
						cmd.pop2 = 1'b1;
						if (sts.b_zero) begin
							st_d    = smeu_pkg::ST_DIV0;
							state_d = S_RF1;
						end else begin
							cmd.div_start = 1'b1;
							state_d       = S_DIV;
						end
					end
					[smeu_pkg::K_BEQ:smeu_pkg::K_BGEZ]: begin
						cmd.pop2      = 1'b1;
						cmd.pc_ld_tos = sts.br_taken;
						state_d       = S_RF1;
					end
					[smeu_pkg::K_ST8:smeu_pkg::K_ST1]: begin
						cmd.pop2 = 1'b1;
						if (!sts.addr_ok) begin
							st_d    = smeu_pkg::ST_ADDR;
							state_d = S_RF1;
						end else begin
							cmd.bcnt_clr = 1'b1;
							state_d      = S_STW;
						end
					end
					default: begin
						cmd.pop2 = 1'b1;
						state_d  = S_PUSH;
					end
				endcase
			end
			S_MUL: begin
				if (sts.mul_done)
					state_d = S_PUSH;
			end
			S_DIV: begin
				if (sts.div_done)
					state_d = S_PUSH;
			end
			S_STW: begin
				cmd.st_wr = 1'b1;
				if (sts.bcnt_last)
					state_d = S_RF1;
				else
					cmd.bcnt_inc = 1'b1;
			end
			S_LDR: begin
				cmd.ld_rd = 1'b1;
				state_d   = S_LDC;
			end
			S_LDC: begin
				cmd.ld_cap = 1'b1;
				if (sts.bcnt_last)
					state_d = S_PUSH;
				else begin
					cmd.bcnt_inc = 1'b1;
					state_d      = S_LDR;
				end
			end
			S_PUSH: begin
				cmd.push = 1'b1;
				state_d  = S_OUT;
			end
			S_RF1: begin
				if (sts.empty) begin
					cmd.tos_zero = 1'b1;
					state_d      = S_OUT;
				end else begin
					cmd.rd_req = 1'b1;
					state_d    = S_RF2;
				end
			end
			S_RF2: begin
				cmd.tos_cap = 1'b1;
				state_d     = S_OUT;
			end
			S_OUT: begin
				if (!(res_v_q && result_stall)) begin
					cmd.out_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			st_q    <= smeu_pkg::ST_OK;
			res_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			if (cmd.out_ld)
				res_v_q <= 1'b1;
			else if (!result_stall)
				res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_in)
			kind_q <= kind;
	end

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> !(res_v_q && result_stall))
		else $error("result register overwritten while held");
	a_take_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> (state_q == S_DEC))
		else $error("accepted item not decoded");
	a_mul_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_start |=> (state_q == S_MUL))
		else $error("multiply started without wait state");
endmodule

@@ rtl/stack_machine_execute_unit_core.sv @@
// Loads read and then capture data memory byte by byte, stores write it byte
// by byte, and multiply and divide wait on iterative units. One item is in
// flight at a time.
// Reset: async, active low. After reset the data memory is cleared one byte
// per cycle, all MEMORY_BYTES bytes, and no item is taken until that ends.
// Stack entries never written hold no defined value; only live ones are read.
module stack_machine_execute_unit_core #(
	parameter int STACK_WORDS  = smeu_pkg::STACK_WORDS_DEF,
	parameter int MEMORY_BYTES = smeu_pkg::MEMORY_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  smeu_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output smeu_pkg::result_t result
);
	// command and status buses between sequencer and datapath
	smeu_pkg::cmd_t cmd;
	smeu_pkg::sts_t sts;

	// sequencer: one state per stack/memory access or wait on a unit
	smeu_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.kind         (item.kind),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	// datapath: stack memory (one read port, registered), byte memory,
	// iterative multiply/divide, and the result register that holds a
	// finished transfer until the consumer takes it
	smeu_dp #(
		.STACK_WORDS  (STACK_WORDS),
		.MEMORY_BYTES (MEMORY_BYTES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.imm    (item.immediate),
		.cmd    (cmd),
		.sts    (sts),
		.res    (result)
	);
endmodule

@@ sim/stack_machine_execute_unit_core_tb.sv @@
// Self-checking testbench for stack_machine_execute_unit_core: a behavioral
// predictor of the stack machine runs on every accepted transfer.
// Depends on rtl/smeu_pkg.sv and rtl/stack_machine_execute_unit_core.sv.
`timescale 1ns / 1ps

module stack_machine_execute_unit_core_tb;

	localparam int NSTK      = smeu_pkg::STACK_WORDS_DEF;
	localparam int NMEM      = smeu_pkg::MEMORY_BYTES_DEF;
	localparam int MAX_CYC   = 1000000;
	localparam int TAIL_CYC  = 120;   // covers the longest divide latency

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_stall;
	smeu_pkg::item_t   item = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	smeu_pkg::result_t result;

	stack_machine_execute_unit_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #5 clk = ~clk;

	// Predicted machine state
	logic [63:0] mdl_stack [NSTK];
	logic [7:0]  mdl_mem [NMEM];
	int          mdl_depth;
	logic [31:0] mdl_pc;
	logic        mdl_halt;

	smeu_pkg::result_t pending_results[$];
	int          n_errors;
	int          n_cycles;
	int          burst_left;
	bit          hold_tgl;   // flipped by a test to request a long receiver hold-off
	int          hold_len;

	initial begin
		foreach (mdl_mem[i]) mdl_mem[i] = 8'h00;
		foreach (mdl_stack[i]) mdl_stack[i] = 64'h0;
		mdl_depth = 0;
		mdl_pc = 32'h0;
		mdl_halt = 1'b0;
		n_errors = 0;
		burst_left = 0;
		hold_tgl = 1'b0;
		hold_len = 0;
	end

	// Run length guard
	initial n_cycles = 0;
	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles > MAX_CYC) begin
			$display("stack_machine_execute_unit_core_tb: FAIL");
			$finish;
		end
	end

	function automatic bit mem_ok(logic [63:0] addr, int sz);
		return addr <= 64'(NMEM - sz);
	endfunction

	// Executes one instruction on the predicted state and returns the result
	function automatic smeu_pkg::result_t exec_insn(logic [5:0] k, logic [63:0] imm);
		logic [63:0] a, b, r, ma, mb, q, m;
		logic [2:0]  st;
		int          sz;
		bit          na, nb, take;
		smeu_pkg::result_t res;
		st = smeu_pkg::ST_OK;
		a = '0;
		b = '0;
		if (!mdl_halt) begin
			mdl_pc = mdl_pc + 32'd1;
			if (k == smeu_pkg::K_NOP) begin
			end else if (k == smeu_pkg::K_HALT) begin
				mdl_halt = 1'b1;
			end else if (k == smeu_pkg::K_PUSH) begin
				if (mdl_depth >= NSTK) st = smeu_pkg::ST_OVER;
				else begin
					mdl_pc = mdl_pc + 32'd8;
					mdl_stack[mdl_depth] = imm;
					mdl_depth++;
				end
			end else if (k == smeu_pkg::K_POP) begin
				if (mdl_depth == 0) st = smeu_pkg::ST_UNDER;
				else mdl_depth--;
			end else if (k == smeu_pkg::K_CALL) begin
				if (mdl_depth < 1) st = smeu_pkg::ST_UNDER;
				else begin
					a = mdl_stack[mdl_depth-1];
					mdl_stack[mdl_depth-1] = 64'(mdl_pc);
					mdl_pc = a[31:0];
				end
			end else if (k == smeu_pkg::K_JUMP) begin
				if (mdl_depth < 1) st = smeu_pkg::ST_UNDER;
				else begin
					mdl_depth--;
					mdl_pc = mdl_stack[mdl_depth][31:0];
				end
			end else if (k >= smeu_pkg::K_LD8 && k <= smeu_pkg::K_LD1) begin
				sz = 8 >> (k - smeu_pkg::K_LD8);
				if (mdl_depth < 1) st = smeu_pkg::ST_UNDER;
				else begin
					mdl_depth--;
					a = mdl_stack[mdl_depth];
					if (!mem_ok(a, sz)) st = smeu_pkg::ST_ADDR;
					else begin
						r = '0;
						for (int i = 0; i < sz; i++)
							r[8*i +: 8] = mdl_mem[a[15:0] + i];
						mdl_stack[mdl_depth] = r;
						mdl_depth++;
					end
				end
			end else if (k > smeu_pkg::K_LD1) begin
				st = smeu_pkg::ST_INV;
			end else if (mdl_depth < 2) begin
				st = smeu_pkg::ST_UNDER;
			end else begin
				mdl_depth--;
				b = mdl_stack[mdl_depth];
				mdl_depth--;
				a = mdl_stack[mdl_depth];
				if (k <= smeu_pkg::K_NOR) begin
					na = a[63];
					nb = b[63];
					ma = na ? -a : a;
					mb = nb ? -b : b;
					r = '0;
					case (k)
						smeu_pkg::K_UADD, smeu_pkg::K_SADD: r = a + b;
						smeu_pkg::K_USUB, smeu_pkg::K_SSUB: r = a - b;
						smeu_pkg::K_UMUL, smeu_pkg::K_SMUL: r = a * b;
						smeu_pkg::K_UDIV:
							if (b == 0) st = smeu_pkg::ST_DIV0; else r = a / b;
						smeu_pkg::K_UREM:
							if (b == 0) st = smeu_pkg::ST_DIV0; else r = a % b;
						smeu_pkg::K_SDIV, smeu_pkg::K_SREM: begin
							if (b == 0) st = smeu_pkg::ST_DIV0;
							else begin
								q = ma / mb;
								m = ma % mb;
								if (k == smeu_pkg::K_SDIV) r = (na != nb) ? -q : q;
								else r = na ? -m : m;
							end
						end
						smeu_pkg::K_SHL: r = (b >= 64) ? 64'h0 : (a << b[5:0]);
						smeu_pkg::K_SHR: r = (b >= 64) ? 64'h0 : (a >> b[5:0]);
						smeu_pkg::K_AND: r = a & b;
						smeu_pkg::K_OR:  r = a | b;
						smeu_pkg::K_XOR: r = a ^ b;
						default: r = ~(a | b);
					endcase
					if (st == smeu_pkg::ST_OK) begin
						mdl_stack[mdl_depth] = r;
						mdl_depth++;
					end
				end else if (k <= smeu_pkg::K_BGEZ) begin
					case (k)
						smeu_pkg::K_BEQ:  take = (a == 0);
						smeu_pkg::K_BNE:  take = (a != 0);
						smeu_pkg::K_BLTZ: take = a[63];
						smeu_pkg::K_BLEZ: take = a[63] || a == 0;
						smeu_pkg::K_BGTZ: take = !a[63] && a != 0;
						default: take = !a[63];
					endcase
					if (take) mdl_pc = b[31:0];
				end else begin
					sz = 8 >> (k - smeu_pkg::K_ST8);
					if (!mem_ok(b, sz)) st = smeu_pkg::ST_ADDR;
					else
						for (int i = 0; i < sz; i++)
							mdl_mem[b[15:0] + i] = a[8*i +: 8];
				end
			end
		end
		res.status = st;
		res.next_pc = mdl_pc;
		res.halted = mdl_halt;
		res.stack_top = (mdl_depth != 0) ? mdl_stack[mdl_depth-1] : 64'h0;
		res.stack_count = 9'(mdl_depth);
		return res;
	endfunction

	// Offers one instruction; returns after its transfer, at a rising edge
	task automatic send_insn(logic [5:0] k, logic [63:0] imm);
		int g;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
			                                         : $urandom_range(1, 12);
			g = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
			if (g > 0) begin
				item_valid <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
		burst_left--;
		item_valid <= 1'b1;
		item <= '{kind: k, immediate: imm};
		@(negedge clk);
		while (item_stall) @(negedge clk);
		@(posedge clk);
		pending_results.push_back(exec_insn(k, imm));
	endtask

	// Lets every expected result arrive, then the block's tail
	task automatic drain();
		item_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYC) @(posedge clk);
	endtask

	function automatic logic [63:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 64'h0;
			1: return '1;
			2: return 64'h8000_0000_0000_0000;
			3: return 64'h7fff_ffff_ffff_ffff;
			4: return 64'($urandom_range(0, 20));
			5: return -64'($urandom_range(1, 20));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [63:0] pick_addr();
		case ($urandom_range(0, 9))
			0: return 64'($urandom_range(NMEM - 9, NMEM - 1));
			1: return {$urandom, $urandom};
			2: return 64'(NMEM) + 64'($urandom_range(0, 7));
			default: return 64'($urandom_range(0, 63));
		endcase
	endfunction

	// Result checker: a transfer happens at the next rising edge, so sampling
	// at the falling edge sees settled valid, stall and payload.
	always @(negedge clk) begin
		smeu_pkg::result_t e;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %p", $time, result);
				n_errors++;
			end else begin
				e = pending_results.pop_front();
				if (result.status !== e.status) begin
					$display("%0t: status exp %0d got %0d", $time, e.status, result.status);
					n_errors++;
				end
				if (result.next_pc !== e.next_pc) begin
					$display("%0t: next_pc exp %h got %h", $time, e.next_pc, result.next_pc);
					n_errors++;
				end
				if (result.halted !== e.halted) begin
					$display("%0t: halted exp %b got %b", $time, e.halted, result.halted);
					n_errors++;
				end
				if (result.stack_top !== e.stack_top) begin
					$display("%0t: stack_top exp %h got %h", $time, e.stack_top,
					         result.stack_top);
					n_errors++;
				end
				if (result.stack_count !== e.stack_count) begin
					$display("%0t: stack_count exp %0d got %0d", $time, e.stack_count,
					         result.stack_count);
					n_errors++;
				end
			end
		end
	end

	// Receiver stall pattern: the mode is picked at random and changes at random
	// intervals; a long hold-off is served whenever a test flips hold_tgl.
	always @(posedge clk) begin
		int    mode_left;
		int    mode;
		int    hold_cnt;
		bit    hold_seen;
		if (hold_tgl != hold_seen) begin
			hold_seen = hold_tgl;
			hold_cnt = hold_len;
		end
		if (mode_left <= 0) begin
			mode = $urandom_range(0, 3);
			mode_left = $urandom_range(50, 400);
		end
		mode_left--;
		if (hold_cnt > 0) begin
			hold_cnt--;
			result_stall <= 1'b1;
		end else begin
			case (mode)
				0: result_stall <= 1'b0;
				1: result_stall <= ($urandom_range(0, 2) == 0);
				2: result_stall <= (n_cycles % 7) < 3;
				default: result_stall <= ($urandom_range(0, 9) < 7);
			endcase
		end
	end

	// Edge cases: underflow, wraps, division by zero, big shifts, memory edges,
	// invalid opcodes, branches, call and jump
	task automatic test_directed();
		send_insn(smeu_pkg::K_POP, '1);
		send_insn(smeu_pkg::K_JUMP, '0);
		send_insn(smeu_pkg::K_LD8, '0);
		send_insn(smeu_pkg::K_PUSH, 64'h8000_0000_0000_0000);
		send_insn(smeu_pkg::K_UADD, '0);             // one word only
		send_insn(smeu_pkg::K_PUSH, '1);
		send_insn(smeu_pkg::K_SDIV, '0);             // min / -1 wraps
		send_insn(smeu_pkg::K_PUSH, '1);
		send_insn(smeu_pkg::K_SREM, '0);             // min % -1 is 0
		send_insn(smeu_pkg::K_PUSH, 64'd0);
		send_insn(smeu_pkg::K_UREM, '0);             // by zero
		send_insn(smeu_pkg::K_PUSH, 64'hdead_beef_0123_4567);
		send_insn(smeu_pkg::K_PUSH, 64'd64);
		send_insn(smeu_pkg::K_SHL, '0);              // shift of 64 gives 0
		send_insn(smeu_pkg::K_PUSH, 64'hfedc_ba98_7654_3210);
		send_insn(smeu_pkg::K_PUSH, 64'(NMEM - 8));
		send_insn(smeu_pkg::K_ST8, '0);              // last legal quad
		send_insn(smeu_pkg::K_PUSH, 64'(NMEM - 1));
		send_insn(smeu_pkg::K_LD1, '0);
		send_insn(smeu_pkg::K_PUSH, 64'(NMEM - 7));
		send_insn(smeu_pkg::K_LD8, '0);              // runs past the end
		send_insn(6'd63, '1);                        // invalid
		send_insn(smeu_pkg::K_PUSH, 64'h0000_0000_1234_5678);
		send_insn(smeu_pkg::K_CALL, '0);
		send_insn(smeu_pkg::K_BEQ, '0);              // pops the call's pc as target
		drain();
	endtask

	// Fills the stack to overflow with a long receiver hold-off at the start, then empties it to underflow
	task automatic test_stack_limits();
		hold_len = 400;
		hold_tgl = ~hold_tgl;
		while (mdl_depth < NSTK) send_insn(smeu_pkg::K_PUSH, {$urandom, $urandom});
		send_insn(smeu_pkg::K_PUSH, '1);
		send_insn(smeu_pkg::K_PUSH, '0);
		drain();
		while (mdl_depth > 0) send_insn(smeu_pkg::K_POP, {$urandom, $urandom});
		send_insn(smeu_pkg::K_POP, '0);
		drain();
	endtask

	// Mostly well-formed operand/op sequences, with some noise
	task automatic test_random(int n);
		int          sent;
		int          r;
		logic [5:0]  k;
		sent = 0;
		while (sent < n) begin
			r = $urandom_range(0, 99);
			if (mdl_depth > 240) begin
				send_insn(smeu_pkg::K_POP, {$urandom, $urandom});
				sent += 1;
			end else if (r < 12) begin
				send_insn(smeu_pkg::K_PUSH, pick_value());
				sent += 1;
			end else if (r < 42) begin
				k = 6'($urandom_range(smeu_pkg::K_UADD, smeu_pkg::K_NOR));
				send_insn(smeu_pkg::K_PUSH, pick_value());
				if (k == smeu_pkg::K_SHL || k == smeu_pkg::K_SHR)
					send_insn(smeu_pkg::K_PUSH,
					          $urandom_range(0, 3) == 0 ? pick_value()
					                                    : 64'($urandom_range(0, 70)));
				else
					send_insn(smeu_pkg::K_PUSH,
					          $urandom_range(0, 7) == 0 ? 64'h0 : pick_value());
				send_insn(k, {$urandom, $urandom});
				sent += 3;
			end else if (r < 52) begin
				send_insn(smeu_pkg::K_PUSH, pick_value());
				send_insn(smeu_pkg::K_PUSH, {$urandom, $urandom});
				send_insn(6'($urandom_range(smeu_pkg::K_BEQ, smeu_pkg::K_BGEZ)), '0);
				sent += 3;
			end else if (r < 57) begin
				send_insn(smeu_pkg::K_PUSH, {$urandom, $urandom});
				send_insn($urandom_range(0, 1) ? smeu_pkg::K_CALL : smeu_pkg::K_JUMP, '0);
				sent += 2;
			end else if (r < 72) begin
				send_insn(smeu_pkg::K_PUSH, pick_value());
				send_insn(smeu_pkg::K_PUSH, pick_addr());
				send_insn(smeu_pkg::K_ST8 + 6'($urandom_range(0, 3)), '0);
				sent += 3;
			end else if (r < 86) begin
				send_insn(smeu_pkg::K_PUSH, pick_addr());
				send_insn(smeu_pkg::K_LD8 + 6'($urandom_range(0, 3)), '0);
				sent += 2;
			end else if (r < 91) begin
				send_insn(smeu_pkg::K_POP, '0);
				sent += 1;
			end else if (r < 95) begin
				send_insn($urandom_range(0, 1) ? smeu_pkg::K_NOP
				          : smeu_pkg::K_LD1 + 6'($urandom_range(1, 28)),
				          {$urandom, $urandom});
				sent += 1;
			end else begin
				k = 6'($urandom_range(0, 63));
				if (k == smeu_pkg::K_HALT) k = smeu_pkg::K_NOP;   // halt is saved for the last test
				send_insn(k, {$urandom, $urandom});
				sent += 1;
			end
		end
		drain();
	endtask

	// After halt every transfer is ignored
	task automatic test_halt();
		send_insn(smeu_pkg::K_PUSH, 64'h55);
		send_insn(smeu_pkg::K_HALT, '0);
		send_insn(smeu_pkg::K_PUSH, '1);
		send_insn(smeu_pkg::K_POP, '0);
		send_insn(6'd50, '0);
		send_insn(smeu_pkg::K_HALT, '1);
		drain();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_stack_limits();
		test_random(260);
		test_halt();
		if (n_errors == 0)
			$display("stack_machine_execute_unit_core_tb: PASS");
		else
			$display("stack_machine_execute_unit_core_tb: FAIL");
		$finish;
	end

endmodule
